>>> sv/lkv_pkg.sv
`timescale 1ns / 1ps
// Package: sizes, types and controller-to-datapath command for the LRU key-value cache.
package lkv_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;

   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CAP_BITS   = 5;
   localparam int CMP_BITS   = (CAP_BITS > COUNT_BITS) ? CAP_BITS : COUNT_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic search;    // compare tags, pick target slot
      logic apply;     // update entries, load result register
   } cmd_type;

endpackage

>>> sv/lkv_if.sv
`timescale 1ns / 1ps
// Interfaces: request and response channels of the LRU key-value cache.
interface lkv_req_if import lkv_pkg::*;;
   logic      valid;
   logic      ready;
   logic      mode;
   key_type   key;
   value_type value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*;;
   logic      valid;
   logic      ready;
   logic      hit;
   value_type read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

>>> sv/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// Top level: LRU key-value cache, controller plus datapath.
//
//   channel   direction  transfer when        payload
//   req_chan  in         valid & ready        mode, key, value
//   rsp_chan  out        valid & ready        hit, read_value
//   csr       in         csr_wr_en            csr_wr_data (capacity)
//
// Each request goes through capture, one parallel tag compare over all entries,
// then the entry and recency update that also loads the result register.
// A new request is taken while the previous result still waits; the update step
// holds while the result register is full and not being read.
// Reset clears valid bits, ranks and live count; capacity returns to 16.
module lru_key_value_cache_top import lkv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lkv_req_if.sink    req_chan,
   lkv_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  cap_type    csr_wr_data
);

   cmd_type cmd;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   lkv_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_chan.mode),
      .req_key        (req_chan.key),
      .req_value      (req_chan.value),
      .rsp_hit        (rsp_chan.hit),
      .rsp_read_value (rsp_chan.read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

endmodule

>>> sv/lkv_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences capture, search and apply, owns the response valid.
module lkv_ctrl import lkv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_APPLY  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            // hold until the result register can take the new result
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/lkv_dpath.sv
`timescale 1ns / 1ps
// Datapath: entry tags, values, recency ranks, capacity and the result register.
module lkv_dpath import lkv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      req_mode,
   input  key_type   req_key,
   input  value_type req_value,
   output logic      rsp_hit,
   output value_type rsp_read_value,
   input  logic      csr_wr_en,
   input  cap_type   csr_wr_data
);

   // request holding registers
   logic      mode_ff;
   key_type   key_ff;
   value_type value_ff;

   // entry state
   logic      valid_ff [ENTRIES];
   logic      valid_in [ENTRIES];
   idx_type   rank_ff  [ENTRIES];
   idx_type   rank_in  [ENTRIES];
   key_type   tag_ff   [ENTRIES];
   value_type ent_value_mem [ENTRIES];
   count_type live_ff, live_in;
   cap_type   cap_ff;

   // search results
   logic      hit_ff, hit_in;
   logic      update_ff, update_in;
   logic      grow_ff, grow_in;
   idx_type   target_ff, target_in;

   logic      result_hit_ff;
   value_type result_value_ff;

   logic [CMP_BITS-1:0] cap_ext, eff_cap, live_ext;
   logic      room;
   idx_type   hit_idx, free_idx, victim_idx, last_rank, target_rank;
   logic      any_hit;

   assign rsp_hit        = result_hit_ff;
   assign rsp_read_value = result_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // a zero capacity acts as one, anything above the entry count as the entry count
   always_comb begin
      cap_ext  = CMP_BITS'(cap_ff);
      live_ext = CMP_BITS'(live_ff);
      eff_cap  = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end
      room = (live_ext < eff_cap);
   end

   // ranks form a permutation of 0..live-1, so the least recent holds live-1
   assign last_rank = live_ff[IDX_BITS-1:0] - 1'b1;

   always_comb begin
      any_hit    = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == key_ff) begin
            any_hit = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
         if (valid_ff[i] && rank_ff[i] == last_rank) begin
            victim_idx = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      hit_in    = hit_ff;
      update_in = update_ff;
      grow_in   = grow_ff;
      target_in = target_ff;
      if (cmd.search) begin
         hit_in    = any_hit;
         update_in = any_hit || (mode_ff == MODE_PUT);
         grow_in   = !any_hit && (mode_ff == MODE_PUT) && room;
         if (any_hit) begin
            target_in = hit_idx;
         end else if (room) begin
            target_in = free_idx;
         end else begin
            target_in = victim_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff    <= hit_in;
      update_ff <= update_in;
      grow_ff   <= grow_in;
      target_ff <= target_in;
   end

   assign target_rank = rank_ff[target_ff];

   // promote the target to most recent; others ranked above it (all others on a grow) age by one
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (cmd.apply && update_ff) begin
            if (target_ff == IDX_BITS'(i)) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i] && (grow_ff || rank_ff[i] < target_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
      live_in = live_ff;
      if (cmd.apply && grow_ff) begin
         live_in = live_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         live_ff <= '0;
         cap_ff  <= CAP_RESET;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
         live_ff <= live_in;
         // capacity only changes while the store is empty
         if (csr_wr_en && live_ff == '0) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && update_ff) begin
         tag_ff[target_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && update_ff && mode_ff == MODE_PUT) begin
         ent_value_mem[target_ff] <= value_ff;
      end
      if (cmd.apply) begin
         result_hit_ff <= hit_ff;
         if (hit_ff && mode_ff == MODE_GET) begin
            result_value_ff <= ent_value_mem[target_ff];
         end else begin
            result_value_ff <= '0;
         end
      end
   end

endmodule

>>> verif/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
// Testbench: LRU key-value cache checked against a shadow store with recency ranks.
module lru_key_value_cache_top_tb;
   import lkv_pkg::*;

   localparam int POOL_SIZE   = 20;
   localparam int DRAIN_LIMIT = 4000;

   typedef struct packed {
      logic      hit;
      value_type read_value;
   } lookup_result_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en;
   cap_type csr_wr_data;

   lkv_req_if req_chan ();
   lkv_rsp_if rsp_chan ();

   lru_key_value_cache_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the store
   key_type     shadow_key   [ENTRIES];
   value_type   shadow_value [ENTRIES];
   bit          shadow_live  [ENTRIES];
   int unsigned shadow_rank  [ENTRIES];
   int unsigned shadow_count;
   cap_type     shadow_capacity;

   lookup_result_type lookup_results_q[$];
   key_type           key_pool[POOL_SIZE];
   int                mismatch_count;
   int                rsp_hold_cycles;
   bit                req_idle_on;
   bit                rsp_idle_on;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned effective_capacity();
      if (shadow_capacity == 0) return 1;
      if (shadow_capacity > ENTRIES) return ENTRIES;
      return shadow_capacity;
   endfunction

   // move slot s to the front; live slots ranked below limit shift back one
   function automatic void make_recent(int s, int unsigned limit);
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != s && shadow_live[i] && shadow_rank[i] < limit) shadow_rank[i]++;
      end
      shadow_rank[s] = 0;
   endfunction

   function automatic lookup_result_type access_cache(logic mode, key_type key,
                                                      value_type value);
      lookup_result_type res;
      int                found;
      int                slot;
      int                victim;
      int unsigned       worst;
      found          = -1;
      res.hit        = 1'b0;
      res.read_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && shadow_live[i] && shadow_key[i] == key) found = i;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (mode == MODE_GET) res.read_value = shadow_value[found];
         else shadow_value[found] = value;
         make_recent(found, shadow_rank[found]);
      end else if (mode == MODE_PUT) begin
         if (shadow_count < effective_capacity()) begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !shadow_live[i]) slot = i;
            end
            shadow_live[slot]  = 1'b1;
            shadow_key[slot]   = key;
            shadow_value[slot] = value;
            make_recent(slot, 32'hFFFF_FFFF);
            shadow_count++;
         end else begin
            // evict the least recent live entry and reuse its slot
            victim = -1;
            worst  = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (shadow_live[i] && (victim < 0 || shadow_rank[i] > worst)) begin
                  victim = i;
                  worst  = shadow_rank[i];
               end
            end
            shadow_key[victim]   = key;
            shadow_value[victim] = value;
            make_recent(victim, worst);
         end
      end
      return res;
   endfunction

   task automatic send_request(input logic mode, input key_type key, input value_type value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.key   <= key;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      lookup_results_q.push_back(access_cache(mode, key, value));
   endtask

   // drop valid and wait for every outstanding response
   task automatic drain_lookups();
      int cycles;
      lookup_result_type lost;
      cycles = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (lookup_results_q.size() != 0 && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      while (lookup_results_q.size() != 0) begin
         lost = lookup_results_q.pop_front();
         report_mismatch($sformatf("response never arrived: hit=%0b read_value=%h",
                                   lost.hit, lost.read_value));
      end
   endtask

   task automatic write_capacity(input cap_type cap);
      drain_lookups();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      if (shadow_count == 0) shadow_capacity = cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_access();
      logic      mode;
      key_type   key;
      value_type value;
      int        pick;
      mode = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 85) key = key_pool[$urandom_range(0, effective_capacity() + 3)];
      else key = key_type'($urandom);
      // refresh the working set now and then
      if (pick == 99) key_pool[$urandom_range(2, POOL_SIZE - 1)] = key_type'($urandom);
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom;
      endcase
      send_request(mode, key, value);
   endtask

   task automatic test_empty_store();
      cap_type cap;
      case ($urandom_range(0, 5))
         0:       cap = 5'd0;
         1:       cap = 5'd1;
         2:       cap = 5'd16;
         3:       cap = 5'd31;
         default: cap = cap_type'($urandom_range(2, 15));
      endcase
      write_capacity(5'd0);
      send_request(MODE_GET, 16'h0000, 32'hFFFF_FFFF);
      write_capacity(5'd31);
      send_request(MODE_GET, 16'hFFFF, 32'h0);
      write_capacity(cap);
      send_request(MODE_GET, key_type'($urandom), $urandom);
   endtask

   task automatic test_basic_ops();
      send_request(MODE_PUT, 16'h0000, 32'h0000_0000);
      send_request(MODE_PUT, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(MODE_GET, 16'hFFFF, 32'h0);
      send_request(MODE_GET, 16'h0000, 32'hFFFF_FFFF);
      send_request(MODE_PUT, 16'h0000, 32'hA5A5_5A5A);
      send_request(MODE_GET, 16'h0000, 32'h0);
      send_request(MODE_GET, 16'h1234, 32'h0);
   endtask

   task automatic test_eviction();
      int unsigned n;
      n = effective_capacity();
      for (int i = 0; i < n; i++) send_request(MODE_PUT, key_type'(16'h8000 + i), $urandom);
      send_request(MODE_GET, 16'h8000, 32'h0);
      send_request(MODE_PUT, 16'h9000, $urandom);
      send_request(MODE_GET, 16'h8001, 32'h0);
      send_request(MODE_GET, 16'h8000, 32'h0);
   endtask

   // store is not empty, so the write must not take effect
   task automatic test_capacity_ignored();
      write_capacity((effective_capacity() == 1) ? 5'd16 : 5'd1);
      for (int i = 0; i < 40; i++) send_random_access();
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         send_random_access();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < 150; i++) send_random_access();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_receiver_stall();
      req_idle_on     = 1'b0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 40; i++) send_random_access();
      req_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 20; i++) send_random_access();
      drain_lookups();
      for (int i = 0; i < 20; i++) send_random_access();
   endtask

   // response ready: random gaps per transfer, plus an optional long hold
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (lookup_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response: hit=%0b read_value=%h",
                                      rsp_chan.hit, rsp_chan.read_value));
         end else begin
            want = lookup_results_q.pop_front();
            if (rsp_chan.hit !== want.hit)
               report_mismatch($sformatf("hit: got %b, want %b", rsp_chan.hit, want.hit));
            if (rsp_chan.read_value !== want.read_value)
               report_mismatch($sformatf("read_value: got %h, want %h",
                                         rsp_chan.read_value, want.read_value));
         end
      end
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      mismatch_count  = 0;
      rsp_hold_cycles = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_live[i]  = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_rank[i]  = 0;
      end
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_type'($urandom);
      req_chan.valid <= 1'b0;
      req_chan.mode  <= MODE_GET;
      req_chan.key   <= '0;
      req_chan.value <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_basic_ops();
      test_eviction();
      test_capacity_ignored();
      test_random_mix(300);
      test_back_to_back();
      test_receiver_stall();
      test_sender_pause();
      test_random_mix(150);

      drain_lookups();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
